>>> rtl/core/sbe_pkg.sv
// Shared types and constants for the seven-bit base-91 encoder.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package sbe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned VAL_W       = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned PAIR_W      = 2 * VAL_W + 1;
  localparam int unsigned GROUP_SIZE  = 13;
  localparam int unsigned FILL_W      = 4;
  localparam int unsigned PAIR_CNT_W  = 3;
  localparam int unsigned VALS_PER_JOB = 4;
  localparam int unsigned BASE_CHARS  = 91;
  localparam int unsigned CHAR_OFFSET = 32;
  localparam int unsigned BAD_PAIR    = 90 * 91 + 90;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Reciprocal of the base for the quotient digit; exact for all 13-bit pairs.
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / BASE_CHARS + 1;
  localparam int unsigned RECIP_W     = 14;

  localparam logic [CHAR_W-1:0] END_HI = CHAR_W'(BAD_PAIR / BASE_CHARS + CHAR_OFFSET);
  localparam logic [CHAR_W-1:0] END_LO = CHAR_W'(BAD_PAIR % BASE_CHARS + CHAR_OFFSET);
  localparam logic [VAL_W-1:0]  TOP_FLAG = VAL_W'(1) << (VAL_W - 1);

  // Command codes on the input channel.
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // One queued job: the four 6-bit values of a triple, and whether the
  // stream ends after it.
  typedef struct packed {
    logic                                flush;
    logic [VALS_PER_JOB-1:0][VAL_W-1:0]  vals;
  } job_t;

  typedef enum logic [2:0] {
    B_VAL,
    B_Z1,
    B_Z2,
    B_CNT,
    B_HI,
    B_LO,
    B_ROT
  } back_state_t;

endpackage

>>> rtl/core/seven_bit_base91_encoder.sv
// Seven-bit base-91 encoder. Input beats carry a data byte (cmd 0) or an
// end-of-stream command (cmd 1); output beats carry one printable character
// (32..122) each, with last_of_run marking the final character that an input
// beat causes. Data bytes are taken one per cycle while the job queue has
// room; every third byte and every end-of-stream command becomes a job. The
// back end stores each job's 6-bit values one at a time, sends each full group
// of 12 characters once it finds the store full before a further value, and
// then realigns the store. An end-of-stream command takes, in the back end,
// its four values, three trailer characters, the closing group (its
// characters plus the realignment) and, if its triple overflows the store, a
// full group before them. The queue holds QUEUE_DEPTH jobs.
// Uses sbe_pkg, sbe_front, sbe_queue and sbe_back.
module seven_bit_base91_encoder import sbe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              last_of_run
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t head_job;
  logic head_valid;

  sbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  sbe_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (push_job),
    .full      (q_full),
    .pop       (pop),
    .rd_job    (head_job),
    .not_empty (head_valid)
  );

  sbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .job_valid   (head_valid),
    .job_pop     (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule

>>> rtl/core/sbe_front.sv
// Front end: takes input beats, gathers bytes into triples and turns each
// finished triple or end-of-stream command into a job. Uses sbe_pkg.
module sbe_front import sbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job
);

  logic [BYTE_W-1:0] triple_bytes [3];
  logic [1:0]        triple_fill;
  logic              accept;
  logic [BYTE_W-1:0] b0;
  logic [BYTE_W-1:0] b1;
  logic [BYTE_W-1:0] b2;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && ((cmd == CMD_FLUSH) || (triple_fill == 2'd2));

  assign b0 = triple_bytes[0];
  assign b1 = triple_bytes[1];
  assign b2 = (cmd == CMD_FLUSH) ? triple_bytes[2] : data_byte;

  // A partial triple carries its byte count in the fourth value.
  always_comb begin
    push_job.flush   = (cmd == CMD_FLUSH);
    push_job.vals[0] = b0[7:2];
    push_job.vals[1] = {b0[1:0], b1[7:4]};
    push_job.vals[2] = {b1[3:0], b2[7:6]};
    push_job.vals[3] = (cmd == CMD_FLUSH) ? VAL_W'(triple_fill) : b2[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      triple_fill     <= '0;
      triple_bytes[0] <= '0;
      triple_bytes[1] <= '0;
      triple_bytes[2] <= '0;
    end else if (accept) begin
      if (cmd == CMD_FLUSH) begin
        triple_fill <= '0;
      end else begin
        triple_bytes[triple_fill] <= data_byte;
        triple_fill <= (triple_fill == 2'd2) ? 2'd0 : triple_fill + 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/sbe_queue.sv
// Short job queue between the front and back ends.
// Uses sbe_pkg for the job type.
module sbe_queue import sbe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

>>> rtl/core/sbe_back.sv
// Back end: appends job values to the 13-entry group store, sends groups as
// base-91 character pairs and emits the end-of-stream trailer. Uses sbe_pkg.
module sbe_back import sbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  job_t              job,
  input  logic              job_valid,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              last_of_run
);

  localparam int unsigned PROD_W = PAIR_W + RECIP_W;

  back_state_t             state, state_next;
  logic [1:0]              j, j_next;
  logic [FILL_W-1:0]       fill, fill_next;
  logic [VAL_W-1:0]        store [GROUP_SIZE];
  logic [VAL_W-1:0]        store_next [GROUP_SIZE];
  logic [VAL_W-1:0]        store_rot [GROUP_SIZE];
  logic [VAL_W-1:0]        top, top_next;
  logic [PAIR_CNT_W-1:0]   k, k_next;
  logic [PAIR_CNT_W-1:0]   npairs, npairs_next;
  logic [FILL_W-1:0]       rot, rot_next;
  logic [CHAR_W-1:0]       qdig, qdig_next;
  logic [PAIR_W-1:0]       pv, pv_next;
  logic                    ret_val, ret_val_next;
  logic                    send_last, send_last_next;
  logic                    out_valid_next;
  logic [CHAR_W-1:0]       out_char_next;
  logic                    last_next;

  logic                    adv;
  logic                    emit;
  logic [CHAR_W-1:0]       emit_char;
  logic                    emit_last;
  logic [PAIR_W-1:0]       pair_v;
  logic [PROD_W-1:0]       prod;
  logic [CHAR_W-1:0]       quo;
  logic [PAIR_W-1:0]       rem_full;
  logic                    group_full;
  logic [FILL_W:0]         fill_plus;
  logic [PAIR_CNT_W-1:0]   flush_pairs;
  logic [VAL_W-1:0]        flush_top;

  assign adv = !out_valid || out_ready;

  // Entries 0 and 1 are always the pair being sent; the store turns one
  // place per character and then on at the end until it has made a full turn and lines up again.
  assign pair_v   = {top[VAL_W-1], store[0], store[1]};
  assign prod     = PROD_W'(pair_v) * PROD_W'(RECIP);
  assign quo      = prod[RECIP_SHIFT +: CHAR_W];
  assign rem_full = pv - PAIR_W'(qdig) * PAIR_W'(BASE_CHARS);

  always_comb begin
    for (int i = 0; i < GROUP_SIZE - 1; i++) begin
      store_rot[i] = store[i + 1];
    end
    store_rot[GROUP_SIZE-1] = store[0];
  end

  assign group_full  = (fill == FILL_W'(GROUP_SIZE));
  assign fill_plus   = (FILL_W + 1)'(fill) + (FILL_W + 1)'(1);
  assign flush_pairs = group_full ? PAIR_CNT_W'(GROUP_SIZE / 2)
                                  : fill_plus[PAIR_CNT_W:1];
  assign flush_top   = group_full ? store[GROUP_SIZE-1]
                                  : (fill[0] ? TOP_FLAG : '0);

  always_comb begin
    state_next     = state;
    j_next         = j;
    fill_next      = fill;
    store_next     = store;
    top_next       = top;
    k_next         = k;
    npairs_next    = npairs;
    rot_next       = rot;
    qdig_next      = qdig;
    pv_next        = pv;
    ret_val_next   = ret_val;
    send_last_next = send_last;
    job_pop        = 1'b0;
    emit           = 1'b0;
    emit_char      = END_HI;
    emit_last      = 1'b0;

    case (state)
      B_VAL: begin
        if (job_valid) begin
          if (group_full) begin
            // A value arrives at a full store: send the group first.
            fill_next      = '0;
            top_next       = store[GROUP_SIZE-1];
            npairs_next    = PAIR_CNT_W'(GROUP_SIZE / 2);
            k_next         = '0;
            ret_val_next   = 1'b1;
            send_last_next = !job.flush;
            state_next     = B_HI;
          end else begin
            store_next[fill] = job.vals[j];
            fill_next        = fill + FILL_W'(1);
            j_next           = j + 2'd1;
            if (j == 2'(VALS_PER_JOB - 1)) begin
              if (job.flush) begin
                state_next = B_Z1;
              end else begin
                job_pop = 1'b1;
              end
            end
          end
        end
      end
      B_Z1: begin
        if (adv) begin
          emit       = 1'b1;
          emit_char  = END_HI;
          state_next = B_Z2;
        end
      end
      B_Z2: begin
        if (adv) begin
          emit       = 1'b1;
          emit_char  = END_LO;
          state_next = B_CNT;
        end
      end
      B_CNT: begin
        if (adv) begin
          emit      = 1'b1;
          emit_char = CHAR_W'(fill) + CHAR_W'(CHAR_OFFSET);
          emit_last = (fill == '0);
          if (fill == '0) begin
            job_pop    = 1'b1;
            state_next = B_VAL;
          end else begin
            top_next       = flush_top;
            npairs_next    = flush_pairs;
            k_next         = '0;
            ret_val_next   = 1'b0;
            send_last_next = 1'b1;
            state_next     = B_HI;
          end
        end
      end
      B_HI: begin
        if (adv) begin
          emit       = 1'b1;
          emit_char  = quo + CHAR_W'(CHAR_OFFSET);
          qdig_next  = quo;
          pv_next    = pair_v;
          top_next   = {top[VAL_W-2:0], 1'b0};
          store_next = store_rot;
          rot_next   = rot + FILL_W'(1);
          state_next = B_LO;
        end
      end
      B_LO: begin
        if (adv) begin
          emit       = 1'b1;
          emit_char  = rem_full[CHAR_W-1:0] + CHAR_W'(CHAR_OFFSET);
          emit_last  = send_last && (k == npairs - PAIR_CNT_W'(1));
          store_next = store_rot;
          rot_next   = rot + FILL_W'(1);
          k_next     = k + PAIR_CNT_W'(1);
          state_next = (k == npairs - PAIR_CNT_W'(1)) ? B_ROT : B_HI;
        end
      end
      B_ROT: begin
        store_next = store_rot;
        if (rot == FILL_W'(GROUP_SIZE - 1)) begin
          rot_next   = '0;
          state_next = B_VAL;
          if (!ret_val) begin
            job_pop   = 1'b1;
            fill_next = '0;
          end
        end else begin
          rot_next = rot + FILL_W'(1);
        end
      end
      default: begin
        state_next = B_VAL;
      end
    endcase

    out_valid_next = adv ? emit : out_valid;
    out_char_next  = emit ? emit_char : out_char;
    last_next      = emit ? emit_last : last_of_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_VAL;
      j         <= '0;
      fill      <= '0;
      top       <= '0;
      k         <= '0;
      npairs    <= '0;
      rot       <= '0;
      ret_val   <= 1'b0;
      send_last <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        store[i] <= '0;
      end
    end else begin
      state     <= state_next;
      j         <= j_next;
      fill      <= fill_next;
      top       <= top_next;
      k         <= k_next;
      npairs    <= npairs_next;
      rot       <= rot_next;
      ret_val   <= ret_val_next;
      send_last <= send_last_next;
      out_valid <= out_valid_next;
      store     <= store_next;
    end
  end

  always_ff @(posedge clk) begin
    qdig        <= qdig_next;
    pv          <= pv_next;
    out_char    <= out_char_next;
    last_of_run <= last_next;
  end

endmodule

>>> rtl/core/sbe_checker.sv
// Port-level checks for the seven-bit base-91 encoder, bound to the top level.
// Uses sbe_pkg for widths and character limits.
module sbe_checker import sbe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              cmd,
  input logic [BYTE_W-1:0] data_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              last_of_run
);

  // A waiting input beat keeps its command and its byte.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(data_byte))
    else $error("input beat changed while waiting");

  // A stalled output beat keeps its character and its end flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_of_run))
    else $error("output beat changed while stalled");

  // Every character on the output is printable.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= CHAR_W'(CHAR_OFFSET)) && (out_char <= END_HI))
    else $error("output character out of range");

  // Reset leaves no output beat pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind seven_bit_base91_encoder sbe_checker u_sbe_checker (.*);
